/* sv/tmc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths, class and register codes and the arctangent table
// for the tilt motion classifier. Depends on nothing.
package tmc_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int ROTATION_STEPS_DEF  = 16;

    localparam int ACC_FRAC   = 20;   // fraction bits of the angle accumulator
    localparam int PRESCALE   = 12;   // left shift applied to the rotation inputs
    localparam int TABLE_LEN  = 24;
    localparam int STEP_W     = 5;    // indexes TABLE_LEN entries
    localparam int SAMPLE_W   = 16;
    localparam int ROOT_W     = 16;
    localparam int SUMSQ_W    = 32;
    localparam int XY_W       = 32;
    localparam int Z_W        = 29;
    localparam int ANGLE_W    = 16;
    localparam int CLASS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ANGLE_W-1:0]  angle_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_LEVEL      = 3'd0,
        CLS_NOSE_DOWN  = 3'd1,
        CLS_NOSE_UP    = 3'd2,
        CLS_ROLL_LEFT  = 3'd3,
        CLS_ROLL_RIGHT = 3'd4
    } motion_class_t;

    localparam cfg_idx_t REG_LEVEL_LIMIT      = 3'd0;
    localparam cfg_idx_t REG_DOWN_FAR         = 3'd1;
    localparam cfg_idx_t REG_DOWN_NEAR        = 3'd2;
    localparam cfg_idx_t REG_UP_NEAR          = 3'd3;
    localparam cfg_idx_t REG_UP_FAR           = 3'd4;
    localparam cfg_idx_t REG_LEFT_ROLL_LIMIT  = 3'd5;
    localparam cfg_idx_t REG_RIGHT_ROLL_LIMIT = 3'd6;

    // Status of an iterative unit towards its sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 29'sd47185920;
            5'd1:    val = 29'sd27855475;
            5'd2:    val = 29'sd14718068;
            5'd3:    val = 29'sd7471121;
            5'd4:    val = 29'sd3750058;
            5'd5:    val = 29'sd1876857;
            5'd6:    val = 29'sd938658;
            5'd7:    val = 29'sd469357;
            5'd8:    val = 29'sd234682;
            5'd9:    val = 29'sd117342;
            5'd10:   val = 29'sd58671;
            5'd11:   val = 29'sd29335;
            5'd12:   val = 29'sd14668;
            5'd13:   val = 29'sd7334;
            5'd14:   val = 29'sd3667;
            5'd15:   val = 29'sd1833;
            5'd16:   val = 29'sd917;
            5'd17:   val = 29'sd458;
            5'd18:   val = 29'sd229;
            5'd19:   val = 29'sd115;
            5'd20:   val = 29'sd57;
            5'd21:   val = 29'sd29;
            5'd22:   val = 29'sd14;
            5'd23:   val = 29'sd7;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* sv/tmc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the tilt motion classifier: sensor words,
// classification words and configuration writes. Depends on tmc_pkg.

interface tmc_in_if;
    logic             valid;
    logic             ready;
    tmc_pkg::sample_t accel_x;
    tmc_pkg::sample_t accel_y;
    tmc_pkg::sample_t accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface tmc_out_if;
    logic                          valid;
    logic                          ready;
    logic [tmc_pkg::CLASS_W-1:0]   motion_class;
    tmc_pkg::angle_t               pitch_angle;
    tmc_pkg::angle_t               roll_angle;
    logic                          class_changed_by_rule;

    modport source (output valid, output motion_class, output pitch_angle,
                    output roll_angle, output class_changed_by_rule, input ready);
    modport sink   (input valid, input motion_class, input pitch_angle,
                    input roll_angle, input class_changed_by_rule, output ready);
endinterface

interface tmc_cfg_if;
    logic               valid;
    logic               ready;
    tmc_pkg::cfg_idx_t  index;
    tmc_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/tmc_sqrt.sv */
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a 32-bit radicand, two radicand bits
// per cycle. Depends on tmc_pkg.
module tmc_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tmc_pkg::SUMSQ_W-1:0]       radicand,
    output tmc_pkg::unit_stat_t               stat,
    output logic [tmc_pkg::ROOT_W-1:0]        root
);
    import tmc_pkg::*;

    typedef enum logic {Q_IDLE, Q_RUN} qstate_t;

    localparam logic [SUMSQ_W-1:0] FIRST_BIT = SUMSQ_W'(1) << (SUMSQ_W - 2);

    qstate_t            state_reg, state_next;
    logic               done_reg, done_next;
    logic [SUMSQ_W-1:0] num_reg, num_next;
    logic [SUMSQ_W-1:0] res_reg, res_next;
    logic [SUMSQ_W-1:0] bit_reg, bit_next;
    logic [SUMSQ_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (start)
                begin
                    num_next   = radicand;
                    res_next   = '0;
                    bit_next   = FIRST_BIT;
                    state_next = Q_RUN;
                end
            end
            Q_RUN:
            begin
                // take the digit when the remainder covers the trial value
                if (num_reg >= trial)
                begin
                    num_next = num_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    done_next  = 1'b1;
                    state_next = Q_IDLE;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign stat.busy = (state_reg == Q_RUN);
    assign stat.done = done_reg;
    assign root      = res_reg[ROOT_W-1:0];

endmodule

/* sv/tmc_cordic.sv */
`timescale 1ns / 1ps
// Vectoring rotation unit: atan2(numer, mag) in degrees, one rotation per
// cycle, then a rounding and saturation step. Depends on tmc_pkg.
module tmc_cordic #(
    parameter int ANGLE_FRAC_BITS = tmc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int ROTATION_STEPS  = tmc_pkg::ROTATION_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  tmc_pkg::sample_t                  numer,
    input  logic [tmc_pkg::ROOT_W-1:0]        mag,
    output tmc_pkg::unit_stat_t               stat,
    output logic signed [ANGLE_FRAC_BITS+7:0] angle
);
    import tmc_pkg::*;

    localparam int ANG_W = ANGLE_FRAC_BITS + 8;
    localparam int STEPS = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic [Z_W-1:0]    HALF      = Z_W'(1) << (SH - 1);
    localparam logic [Z_W-1:0]    LIMIT     = Z_W'(90) << ANGLE_FRAC_BITS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

    cstate_t                  state_reg, state_next;
    logic                     done_reg, done_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     zero_reg, zero_next;
    logic signed [ANG_W-1:0]  angle_reg, angle_next;

    logic signed [XY_W-1:0]   dx, dy;
    logic signed [Z_W-1:0]    tab;
    logic [Z_W-1:0]           z_mag, z_rnd, z_sat;
    logic signed [ANG_W-1:0]  a_mag;

    assign dx  = y_reg >>> step_reg;
    assign dy  = x_reg >>> step_reg;
    assign tab = atan_entry(step_reg);

    // round half away from zero, then clamp to a right angle
    assign z_mag = z_reg[Z_W-1] ? unsigned'(-z_reg) : unsigned'(z_reg);
    assign z_rnd = (z_mag + HALF) >> SH;
    assign z_sat = (z_rnd > LIMIT) ? LIMIT : z_rnd;
    assign a_mag = signed'(ANG_W'(z_sat));

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        angle_next = angle_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next     = XY_W'({mag, {PRESCALE{1'b0}}});
                    y_next     = XY_W'(numer) <<< PRESCALE;
                    z_next     = '0;
                    zero_next  = (numer == '0);
                    step_next  = '0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                // rotate towards the x axis
                if (y_reg[XY_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - tab;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + tab;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_FIN;
                end
            end
            C_FIN:
            begin
                if (zero_reg)
                begin
                    angle_next = '0;
                end
                else if (z_reg[Z_W-1])
                begin
                    angle_next = -a_mag;
                end
                else
                begin
                    angle_next = a_mag;
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        zero_reg  <= zero_next;
        angle_reg <= angle_next;
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = done_reg;
    assign angle     = angle_reg;

endmodule

/* sv/tilt_motion_classifier_unit.sv */
`timescale 1ns / 1ps
// Top level of the tilt motion classifier: sequencer, shared squarer, tilt
// rules and result register. Depends on tmc_pkg, tmc_if, tmc_sqrt, tmc_cordic.
//
// Usage
//   sensor : one word per accelerometer sample (accel_x, accel_y, accel_z).
//            Ready is high only while the sequencer waits for a new word.
//   motion : one word per sample: class, pitch, roll (degrees, signed, with
//            ANGLE_FRAC_BITS fraction bits, low 16 bits kept) and a flag that
//            says whether a rule set the class or the previous one was held.
//   cfg    : register writes, always ready; write only while no sample is in
//            flight. Unknown indexes are dropped.
//   Per sample: three squaring states, a square root for pitch (16 steps), a
//   rotation for pitch run alongside the square root for roll, then a rotation
//   for roll. A new sample is accepted only after the last result is loaded.
//   The result sits in an output register: the next sample is taken while it
//   waits, and a stalled receiver only holds the sequencer at its last step.
//   Reset loads the register defaults, sets the held class to level and
//   empties the result register.
module tilt_motion_classifier_unit #(
    parameter int ANGLE_FRAC_BITS = tmc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int ROTATION_STEPS  = tmc_pkg::ROTATION_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tmc_in_if.sink     sensor,
    tmc_out_if.source  motion,
    tmc_cfg_if.sink    cfg
);
    import tmc_pkg::*;

    localparam int ANG_W = ANGLE_FRAC_BITS + 8;
    localparam int CMP_W = ANGLE_FRAC_BITS + 9;
    localparam logic signed [ANG_W-1:0] ANGLE_LIM = ANG_W'(90) <<< ANGLE_FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQRT_P, S_ROT_P, S_ROT_R, S_EMIT
    } seq_state_t;

    // configuration registers
    logic [6:0]        level_limit_reg;
    logic signed [7:0] down_far_reg, down_near_reg, up_near_reg, up_far_reg;
    logic signed [7:0] left_roll_limit_reg, right_roll_limit_reg;

    // sequencer and its registered outputs
    seq_state_t    state_reg, state_next;
    logic          sqrt_start_reg, sqrt_start_next;
    logic          rot_start_reg, rot_start_next;
    logic          sqrt_fin_reg, sqrt_fin_next;
    logic          rot_fin_reg, rot_fin_next;
    logic          out_valid_reg, out_valid_next;
    motion_class_t held_class_reg, held_class_next;

    // sample and intermediate results
    sample_t                 ax_reg, ay_reg, az_reg;
    logic [SUMSQ_W-1:0]      sqx_reg, sum_yz_reg, sum_xz_reg;
    logic [ROOT_W-1:0]       root_p_reg;
    logic signed [ANG_W-1:0] pitch_reg;

    // result register
    motion_class_t out_class_reg;
    angle_t        out_pitch_reg, out_roll_reg;
    logic          out_hit_reg;

    logic                    accept_in, out_take, out_load, both_fin;
    sample_t                 sq_op;
    logic signed [SUMSQ_W-1:0] sq_prod;
    logic [SUMSQ_W-1:0]      sqrt_radicand;
    logic [ROOT_W-1:0]       sqrt_root;
    unit_stat_t              sqrt_stat, rot_stat;
    sample_t                 rot_numer;
    logic [ROOT_W-1:0]       rot_mag;
    logic signed [ANG_W-1:0] rot_angle;

    logic signed [CMP_W-1:0] pitch_c, roll_c;
    logic signed [CMP_W-1:0] th_lv, th_df, th_dn, th_un, th_uf, th_lr, th_rr;
    motion_class_t           rule_cls;
    logic                    rule_hit;

    assign accept_in    = sensor.valid && sensor.ready;
    assign sensor.ready = (state_reg == S_IDLE);
    assign out_take     = motion.valid && motion.ready;
    assign out_load     = (state_reg == S_EMIT) && (!out_valid_reg || motion.ready);
    assign both_fin     = (sqrt_fin_reg || sqrt_stat.done) && (rot_fin_reg || rot_stat.done);

    // ---------------------------------------------------------------
    // Configuration port: always ready, unknown indexes ignored
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_limit_reg      <= 7'd10;
            down_far_reg         <= -8'sd40;
            down_near_reg        <= -8'sd20;
            up_near_reg          <= 8'sd20;
            up_far_reg           <= 8'sd60;
            left_roll_limit_reg  <= -8'sd30;
            right_roll_limit_reg <= 8'sd20;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LEVEL_LIMIT:      level_limit_reg      <= cfg.data[6:0];
                REG_DOWN_FAR:         down_far_reg         <= signed'(cfg.data);
                REG_DOWN_NEAR:        down_near_reg        <= signed'(cfg.data);
                REG_UP_NEAR:          up_near_reg          <= signed'(cfg.data);
                REG_UP_FAR:           up_far_reg           <= signed'(cfg.data);
                REG_LEFT_ROLL_LIMIT:  left_roll_limit_reg  <= signed'(cfg.data);
                REG_RIGHT_ROLL_LIMIT: right_roll_limit_reg <= signed'(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared squarer: one axis per cycle in the three squaring states
    // ---------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_SQ_Y:  sq_op = ay_reg;
            S_SQ_Z:  sq_op = az_reg;
            default: sq_op = ax_reg;
        endcase
    end

    assign sq_prod = sq_op * sq_op;

    // ---------------------------------------------------------------
    // Iterative units. Their operands are steered by the state in which
    // the start pulse arrives; both units latch them on start.
    // ---------------------------------------------------------------
    assign sqrt_radicand = (state_reg == S_SQRT_P) ? sum_yz_reg : sum_xz_reg;
    assign rot_numer     = (state_reg == S_ROT_P) ? ax_reg : ay_reg;
    assign rot_mag       = (state_reg == S_ROT_P) ? root_p_reg : sqrt_root;

    tmc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_radicand),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    tmc_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .ROTATION_STEPS  (ROTATION_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start_reg),
        .numer (rot_numer),
        .mag   (rot_mag),
        .stat  (rot_stat),
        .angle (rot_angle)
    );

    // ---------------------------------------------------------------
    // Tilt rules, later rules override earlier ones; strict compares at
    // full angle precision against threshold * 2^ANGLE_FRAC_BITS.
    // ---------------------------------------------------------------
    assign pitch_c = CMP_W'(pitch_reg);
    assign roll_c  = CMP_W'(rot_angle);
    assign th_lv   = signed'(CMP_W'(level_limit_reg) << ANGLE_FRAC_BITS);
    assign th_df   = CMP_W'(down_far_reg) <<< ANGLE_FRAC_BITS;
    assign th_dn   = CMP_W'(down_near_reg) <<< ANGLE_FRAC_BITS;
    assign th_un   = CMP_W'(up_near_reg) <<< ANGLE_FRAC_BITS;
    assign th_uf   = CMP_W'(up_far_reg) <<< ANGLE_FRAC_BITS;
    assign th_lr   = CMP_W'(left_roll_limit_reg) <<< ANGLE_FRAC_BITS;
    assign th_rr   = CMP_W'(right_roll_limit_reg) <<< ANGLE_FRAC_BITS;

    always_comb
    begin
        rule_cls = held_class_reg;
        rule_hit = 1'b0;
        if ((pitch_c > -th_lv) && (pitch_c < th_lv))
        begin
            rule_cls = CLS_LEVEL;
            rule_hit = 1'b1;
        end
        if ((pitch_c > th_df) && (pitch_c < th_dn))
        begin
            rule_cls = CLS_NOSE_DOWN;
            rule_hit = 1'b1;
        end
        if ((pitch_c > th_un) && (pitch_c < th_uf))
        begin
            rule_cls = CLS_NOSE_UP;
            rule_hit = 1'b1;
        end
        if (roll_c < th_lr)
        begin
            rule_cls = CLS_ROLL_LEFT;
            rule_hit = 1'b1;
        end
        if (roll_c > th_rr)
        begin
            rule_cls = CLS_ROLL_RIGHT;
            rule_hit = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_SQ_X;
                end
            end
            S_SQ_X:   state_next = S_SQ_Y;
            S_SQ_Y:   state_next = S_SQ_Z;
            S_SQ_Z:   state_next = S_SQRT_P;
            S_SQRT_P:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_ROT_P;
                end
            end
            S_ROT_P:
            begin
                if (both_fin)
                begin
                    state_next = S_ROT_R;
                end
            end
            S_ROT_R:
            begin
                if (rot_stat.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // start the root for pitch after the squares, then the pitch rotation
    // and the root for roll together, then the roll rotation
    assign sqrt_start_next = (state_reg == S_SQ_Z) ||
                             ((state_reg == S_SQRT_P) && sqrt_stat.done);
    assign rot_start_next  = ((state_reg == S_SQRT_P) && sqrt_stat.done) ||
                             ((state_reg == S_ROT_P) && both_fin);
    // remember which of the two overlapped units has finished
    assign sqrt_fin_next   = (state_reg == S_ROT_P) && !both_fin &&
                             (sqrt_fin_reg || sqrt_stat.done);
    assign rot_fin_next    = (state_reg == S_ROT_P) && !both_fin &&
                             (rot_fin_reg || rot_stat.done);
    assign out_valid_next  = out_load || (out_valid_reg && !out_take);
    assign held_class_next = out_load ? rule_cls : held_class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sqrt_start_reg <= 1'b0;
            rot_start_reg  <= 1'b0;
            sqrt_fin_reg   <= 1'b0;
            rot_fin_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_class_reg <= CLS_LEVEL;
        end
        else
        begin
            state_reg      <= state_next;
            sqrt_start_reg <= sqrt_start_next;
            rot_start_reg  <= rot_start_next;
            sqrt_fin_reg   <= sqrt_fin_next;
            rot_fin_reg    <= rot_fin_next;
            out_valid_reg  <= out_valid_next;
            held_class_reg <= held_class_next;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            ax_reg <= sensor.accel_x;
            ay_reg <= sensor.accel_y;
            az_reg <= sensor.accel_z;
        end
        if (state_reg == S_SQ_X)
        begin
            sqx_reg <= unsigned'(sq_prod);
        end
        if (state_reg == S_SQ_Y)
        begin
            sum_yz_reg <= unsigned'(sq_prod);
        end
        if (state_reg == S_SQ_Z)
        begin
            sum_yz_reg <= sum_yz_reg + unsigned'(sq_prod);
            sum_xz_reg <= sqx_reg + unsigned'(sq_prod);
        end
        if ((state_reg == S_SQRT_P) && sqrt_stat.done)
        begin
            root_p_reg <= sqrt_root;
        end
        if ((state_reg == S_ROT_P) && both_fin)
        begin
            pitch_reg <= rot_angle;
        end
        if (out_load)
        begin
            out_class_reg <= rule_cls;
            out_pitch_reg <= ANGLE_W'(pitch_reg);
            out_roll_reg  <= ANGLE_W'(rot_angle);
            out_hit_reg   <= rule_hit;
        end
    end

    assign motion.valid                 = out_valid_reg;
    assign motion.motion_class          = out_class_reg;
    assign motion.pitch_angle           = out_pitch_reg;
    assign motion.roll_angle            = out_roll_reg;
    assign motion.class_changed_by_rule = out_hit_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_held_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (held_class_reg == out_class_reg))
        else $error("held class differs from the class just issued");

    a_pitch_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> ((pitch_reg <= ANGLE_LIM) && (pitch_reg >= -ANGLE_LIM)))
        else $error("pitch beyond a right angle");

    a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start_reg |-> !sqrt_stat.busy)
        else $error("root unit started while busy");

    a_rot_free: assert property (@(posedge clk) disable iff (!rst_n)
        rot_start_reg |-> !rot_stat.busy)
        else $error("rotation unit started while busy");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_class_reg <= CLS_ROLL_RIGHT))
        else $error("class code out of range");

endmodule
